// File: rtl/smx_pkg.sv
// ----------------------------------------------------------------------------
// smx_pkg
// Shared types and codes for the stack machine executor: opcodes, result
// status codes and the stack command passed from decode to the stack.
// ----------------------------------------------------------------------------
package smx_pkg;

  localparam int unsigned WordW = 64;

  typedef logic [WordW-1:0] word_t;

  typedef enum logic [2:0] {
    OP_PUSH  = 3'd0,
    OP_READ  = 3'd1,
    OP_ADD   = 3'd2,
    OP_PRINT = 3'd3,
    OP_STOP  = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_EOF         = 3'd1,
    ST_ADD_UNDER   = 3'd2,
    ST_PRINT_EMPTY = 3'd3,
    ST_OVERFLOW    = 3'd4,
    ST_STOPPED     = 3'd5,
    ST_HALTED      = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_PUSH = 2'd1,
    CMD_ADD  = 2'd2,
    CMD_POP  = 2'd3
  } stack_cmd_t;

  typedef struct packed {
    word_t   print_value;
    logic    print_valid;
    status_t status;
    logic    halted;
  } result_t;

endpackage

// File: rtl/smx_stack.sv
// ----------------------------------------------------------------------------
// smx_stack
// Data stack with the top two words in registers and the rest in a single
// port-pair memory. A prefetched third word keeps every command to at most
// one memory write and one memory read.
// ----------------------------------------------------------------------------
module smx_stack
  import smx_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 256,
  parameter int unsigned CW = $clog2(STACK_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  stack_cmd_t    cmd,
  input  word_t         push_data,
  output logic [CW-1:0] count,
  output word_t         tos
);

  localparam int unsigned AW = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1;

  word_t         mem [STACK_DEPTH];
  word_t         rd_q;
  word_t         third_fwd;
  logic          third_sel;
  word_t         third;
  word_t         nos;

  logic [CW-1:0] count_next;
  word_t         tos_next;
  word_t         nos_next;
  logic          we;
  logic [CW-1:0] cnt_m2;
  logic [CW-1:0] cnt_m3;
  logic [CW-1:0] cnt_m4;
  logic [AW-1:0] wa;
  logic [AW-1:0] ra;
  logic          fwd_next;

  assign third  = third_sel ? third_fwd : rd_q;
  assign cnt_m2 = count - CW'(2);
  assign cnt_m3 = count - CW'(3);
  assign cnt_m4 = count - CW'(4);
  assign wa     = cnt_m2[AW-1:0];

  always_comb begin
    count_next = count;
    tos_next   = tos;
    nos_next   = nos;
    we         = 1'b0;
    ra         = cnt_m3[AW-1:0];
    fwd_next   = 1'b0;
    unique case (cmd)
      CMD_PUSH: begin
        // spill the second word; it becomes the new third word
        tos_next   = push_data;
        nos_next   = tos;
        count_next = count + CW'(1);
        we         = (count >= CW'(2));
        fwd_next   = 1'b1;
      end
      CMD_ADD: begin
        tos_next   = tos + nos;
        nos_next   = third;
        count_next = count - CW'(1);
        ra         = cnt_m4[AW-1:0];
      end
      CMD_POP: begin
        tos_next   = nos;
        nos_next   = third;
        count_next = count - CW'(1);
        ra         = cnt_m4[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= nos;
    end
    rd_q <= mem[ra];
  end

  always_ff @(posedge clk) begin
    tos       <= tos_next;
    nos       <= nos_next;
    third_fwd <= nos;
    if (rst) begin
      count     <= '0;
      third_sel <= 1'b0;
    end else begin
      count     <= count_next;
      third_sel <= fwd_next;
    end
  end

endmodule

// File: rtl/smx_exec.sv
// ----------------------------------------------------------------------------
// smx_exec
// Instruction decode: checks the stack bounds, picks the stack command,
// forms the result and keeps the halt flag.
// ----------------------------------------------------------------------------
module smx_exec
  import smx_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 256,
  parameter int unsigned CW = $clog2(STACK_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [2:0]    op,
  input  word_t         operand,
  input  logic          operand_present,
  input  logic [CW-1:0] count,
  input  word_t         tos,
  output stack_cmd_t    cmd,
  output word_t         push_data,
  output result_t       result
);

  logic halt_flag;
  logic halt_next;
  logic full;
  logic empty;
  logic lt2;

  assign full      = (count == CW'(STACK_DEPTH));
  assign empty     = (count == '0);
  assign lt2       = (count < CW'(2));
  assign push_data = operand;

  always_comb begin
    cmd                = CMD_NONE;
    halt_next          = halt_flag;
    result.print_value = '0;
    result.print_valid = 1'b0;
    result.status      = ST_OK;
    if (halt_flag) begin
      result.status = ST_HALTED;
    end else begin
      unique case (op)
        OP_PUSH, OP_READ: begin
          if (op == OP_READ && !operand_present) begin
            halt_next     = 1'b1;
            result.status = ST_EOF;
          end else if (full) begin
            halt_next     = 1'b1;
            result.status = ST_OVERFLOW;
          end else begin
            cmd = CMD_PUSH;
          end
        end
        OP_ADD: begin
          if (lt2) begin
            halt_next     = 1'b1;
            result.status = ST_ADD_UNDER;
          end else begin
            cmd = CMD_ADD;
          end
        end
        OP_PRINT: begin
          if (empty) begin
            halt_next     = 1'b1;
            result.status = ST_PRINT_EMPTY;
          end else begin
            cmd                = CMD_POP;
            result.print_value = tos;
            result.print_valid = 1'b1;
          end
        end
        default: begin
          // stop and the unused codes
          halt_next     = 1'b1;
          result.status = ST_STOPPED;
        end
      endcase
    end
    result.halted = halt_next;
    if (!accept) begin
      cmd = CMD_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      halt_flag <= 1'b0;
    end else if (accept) begin
      halt_flag <= halt_next;
    end
  end

endmodule

// File: rtl/stack_machine_executor.sv
// ----------------------------------------------------------------------------
// stack_machine_executor
// Executes one stack-machine instruction per input beat and returns one
// result beat per instruction.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries op, operand and
//   operand_present; the caller walks the program and feeds instructions in
//   order. Output channel (out_valid / out_stall) returns print_value,
//   print_valid, status and halted for every instruction.
//   A result is registered and appears in the cycle after its instruction
//   is accepted. Throughput: one instruction per cycle while not stalled.
//   The top two stack words live in registers and a third is prefetched from
//   the stack memory, so every instruction needs at most one memory write and
//   one memory read. When the receiver stalls with a result held, in_stall
//   rises in the same cycle and the held result stays put until it is taken.
//   Reset clears the stack count, the halt flag and the result valid; the
//   stack memory itself is not cleared and needs no clearing pass.
//   After stop or any error the block reports halted on every later beat
//   until reset.
// ----------------------------------------------------------------------------
module stack_machine_executor
  import smx_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          op,
  input  logic signed [63:0]  operand,
  input  logic                operand_present,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [63:0]  print_value,
  output logic                print_valid,
  output logic [2:0]          status,
  output logic                halted
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  logic          accept;
  stack_cmd_t    cmd;
  word_t         push_data;
  logic [CW-1:0] count;
  word_t         tos;
  result_t       result;
  result_t       out_q;

  // hold input while a result sits unread at a stalled output
  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  smx_exec #(
    .STACK_DEPTH (STACK_DEPTH),
    .CW          (CW)
  ) u_exec (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .op              (op),
    .operand         (operand),
    .operand_present (operand_present),
    .count           (count),
    .tos             (tos),
    .cmd             (cmd),
    .push_data       (push_data),
    .result          (result)
  );

  smx_stack #(
    .STACK_DEPTH (STACK_DEPTH),
    .CW          (CW)
  ) u_stack (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .push_data (push_data),
    .count     (count),
    .tos       (tos)
  );

  // result register: load on accept, drop valid once taken with no new instruction
  always_ff @(posedge clk) begin
    if (accept) begin
      out_q <= result;
    end
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= in_valid;
    end
  end

  assign print_value = out_q.print_value;
  assign print_valid = out_q.print_valid;
  assign status      = out_q.status;
  assign halted      = out_q.halted;

endmodule

// File: tb/stack_machine_executor_tb.sv
// ----------------------------------------------------------------------------
// stack_machine_executor_tb
// Self-checking bench for the stack machine executor. Instruction beats go in
// on the valid/stall input channel, and a shadow stack predicts one result
// per accepted instruction. Each result beat is checked field by field
// against the oldest prediction. Both sides idle at random. The run covers
// wrapping adds, ignored fields, a fill to full depth, a long random program
// and one randomly chosen halt cause, followed by beats sent while halted.
// ----------------------------------------------------------------------------
module stack_machine_executor_tb;
  import smx_pkg::*;

  localparam int unsigned StackDepth    = 256;
  localparam int unsigned RandomItems   = 100;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned IdlePercent   = 33;

  // Opcodes beyond stop behave like stop.
  localparam logic [2:0] OpUnusedLo = 3'd5;
  localparam logic [2:0] OpUnusedHi = 3'd7;

  localparam word_t MaxPos  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam word_t MinNeg  = 64'h8000_0000_0000_0000;
  localparam word_t AllOnes = '1;
  localparam word_t Zero    = '0;

  // The one reset lets the machine halt only once, so the halt cause is
  // picked at random for each seed.
  typedef enum int {
    CAUSE_EOF,
    CAUSE_STOP,
    CAUSE_UNKNOWN_OP,
    CAUSE_ADD_UNDER,
    CAUSE_PRINT_EMPTY,
    CAUSE_OVERFLOW
  } halt_cause_t;

  // Every block input starts at a known value.
  logic               clk             = 1'b0;
  logic               rst             = 1'b1;
  logic               in_valid        = 1'b0;
  logic               in_stall;
  logic [2:0]         op              = '0;
  logic signed [63:0] operand         = '0;
  logic               operand_present = 1'b0;
  logic               out_valid;
  logic               out_stall       = 1'b0;
  logic signed [63:0] print_value;
  logic               print_valid;
  logic [2:0]         status;
  logic               halted;

  // Shadow of the machine: stack words, fill level and halt flag.
  word_t       stack_words [StackDepth];
  int unsigned stack_fill = 0;
  bit          halt_seen  = 1'b0;

  result_t     pending_results [$];
  int unsigned error_count  = 0;
  int unsigned quiet_cycles = 0;
  bit          steady       = 1'b0;

  stack_machine_executor #(
    .STACK_DEPTH(StackDepth)
  ) u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .op             (op),
    .operand        (operand),
    .operand_present(operand_present),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .print_value    (print_value),
    .print_valid    (print_valid),
    .status         (status),
    .halted         (halted)
  );

  always #6 clk = ~clk;

  // Receiver: stall about a third of the cycles, except in the steady stretch.
  always @(negedge clk) begin
    out_stall <= !steady && ($urandom_range(0, 99) < IdlePercent);
  end

  task automatic report_mismatch(string msg);
    $display("ERROR: %s", msg);
    error_count++;
  endtask

  // Place a word on the shadow stack, or flag overflow and halt when full.
  function automatic status_t push_word(word_t v);
    if (stack_fill >= StackDepth) begin
      halt_seen = 1'b1;
      return ST_OVERFLOW;
    end
    stack_words[stack_fill] = v;
    stack_fill++;
    return ST_OK;
  endfunction

  // Execute one instruction on the shadow stack and return the result beat
  // that the block should produce for it.
  function automatic result_t exec_instr(logic [2:0] o, word_t v, logic present);
    result_t r;
    r.print_value = Zero;
    r.print_valid = 1'b0;
    r.status      = ST_OK;
    r.halted      = 1'b0;
    if (halt_seen) begin
      r.status = ST_HALTED;
    end else begin
      case (o)
        OP_PUSH: begin
          r.status = push_word(v);
        end
        OP_READ: begin
          // An absent value marks end of input.
          if (!present) begin
            halt_seen = 1'b1;
            r.status  = ST_EOF;
          end else begin
            r.status = push_word(v);
          end
        end
        OP_ADD: begin
          if (stack_fill < 2) begin
            halt_seen = 1'b1;
            r.status  = ST_ADD_UNDER;
          end else begin
            stack_words[stack_fill-2] = stack_words[stack_fill-1] + stack_words[stack_fill-2];
            stack_fill--;
          end
        end
        OP_PRINT: begin
          if (stack_fill == 0) begin
            halt_seen = 1'b1;
            r.status  = ST_PRINT_EMPTY;
          end else begin
            stack_fill--;
            r.print_value = stack_words[stack_fill];
            r.print_valid = 1'b1;
          end
        end
        default: begin
          // Stop and the unused codes all halt the machine.
          halt_seen = 1'b1;
          r.status  = ST_STOPPED;
        end
      endcase
    end
    r.halted = halt_seen;
    return r;
  endfunction

  // Sample both channels at the rising edge. Check the outgoing beat before
  // predicting the incoming one; a result always belongs to an older
  // instruction, so the order in the queue stays right.
  always @(posedge clk) begin : monitor
    result_t want;
    bit      moved;
    moved = 1'b0;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result beat with none expected, status %0d", status));
        end else begin
          want = pending_results.pop_front();
          if (print_value !== want.print_value)
            report_mismatch($sformatf("print_value %h, expected %h",
                                      print_value, want.print_value));
          if (print_valid !== want.print_valid)
            report_mismatch($sformatf("print_valid %b, expected %b",
                                      print_valid, want.print_valid));
          if (status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
          if (halted !== want.halted)
            report_mismatch($sformatf("halted %b, expected %b", halted, want.halted));
        end
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        pending_results.push_back(exec_instr(op, operand, operand_present));
      end
      // Watchdog: end the run when no beat moves on either side for too long.
      if (moved) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WatchdogLimit) begin
          $display("DONE: errors detected");
          $finish;
        end
      end
    end
  end

  // Mostly random words, with the extremes mixed in often.
  function automatic word_t pick_word();
    case ($urandom_range(0, 9))
      0:       return MaxPos;
      1:       return MinNeg;
      2:       return Zero;
      3:       return AllOnes;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Send one instruction beat. Called and left at a falling edge; valid stays
  // high after acceptance so the next beat can follow back to back.
  task automatic issue_instr(logic [2:0] o, word_t v, logic present);
    while (!steady && ($urandom_range(0, 99) < IdlePercent)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    op              <= o;
    operand         <= v;
    operand_present <= present;
    // Hold the beat until the block takes it.
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid and hold off until every predicted result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Sums that cross the signed extremes wrap modulo 2^64.
  task automatic test_wrapping_add();
    issue_instr(OP_PUSH, MaxPos, 1'b1);
    issue_instr(OP_PUSH, 64'd1, 1'b1);
    issue_instr(OP_ADD, Zero, 1'b0);
    issue_instr(OP_PRINT, Zero, 1'b0);
    issue_instr(OP_PUSH, AllOnes, 1'b1);
    issue_instr(OP_PUSH, MinNeg, 1'b1);
    issue_instr(OP_ADD, Zero, 1'b0);
    issue_instr(OP_PRINT, Zero, 1'b0);
  endtask

  // Read with a supplied value behaves like a push of that value.
  task automatic test_read_supplied();
    issue_instr(OP_READ, {$urandom, $urandom}, 1'b1);
    issue_instr(OP_READ, AllOnes, 1'b1);
    issue_instr(OP_ADD, Zero, 1'b0);
    issue_instr(OP_PRINT, Zero, 1'b0);
  endtask

  // Fields that an op does not use carry junk and must not matter.
  task automatic test_ignored_fields();
    issue_instr(OP_PUSH, MinNeg, 1'b0);
    issue_instr(OP_PUSH, MaxPos, 1'b0);
    issue_instr(OP_ADD, AllOnes, 1'b1);
    issue_instr(OP_PRINT, {$urandom, $urandom}, 1'b1);
  endtask

  // Last in comes out first; add folds the two top entries.
  task automatic test_stack_order();
    issue_instr(OP_PUSH, 64'h0000_0000_0000_0011, 1'b1);
    issue_instr(OP_PUSH, 64'h0000_0000_0000_0022, 1'b1);
    issue_instr(OP_PUSH, 64'h0000_0000_0000_0033, 1'b1);
    issue_instr(OP_PRINT, Zero, 1'b0);
    issue_instr(OP_ADD, Zero, 1'b0);
    issue_instr(OP_PRINT, Zero, 1'b0);
  endtask

  // Random legal program: never underflows or overflows, so the machine keeps
  // running. Unused fields carry junk. A stretch near the start runs with no
  // idling on either side, and halfway through the sender drains fully.
  task automatic test_random_program();
    int unsigned roll;
    op_t         kind;
    logic        present;
    for (int unsigned i = 0; i < RandomItems; i++) begin
      steady = (i >= 10) && (i < 40);
      if (i == RandomItems / 2) wait_drained();
      roll = $urandom_range(0, 99);
      if (roll < 35)      kind = OP_PUSH;
      else if (roll < 50) kind = OP_READ;
      else if (roll < 75) kind = OP_ADD;
      else                kind = OP_PRINT;
      if (kind == OP_ADD && stack_fill < 2) kind = OP_PUSH;
      if (kind == OP_PRINT && stack_fill == 0) kind = OP_PUSH;
      if ((kind == OP_PUSH || kind == OP_READ) && stack_fill >= StackDepth) kind = OP_PRINT;
      present = (kind == OP_READ) ? 1'b1 : 1'($urandom_range(0, 1));
      issue_instr(kind, pick_word(), present);
    end
    steady = 1'b0;
  endtask

  // Fill the stack to its full depth, then pop a few entries back off.
  task automatic test_fill_to_capacity();
    while (stack_fill < StackDepth)
      issue_instr($urandom_range(0, 1) ? OP_READ : OP_PUSH, pick_word(), 1'b1);
    repeat (6) issue_instr(OP_PRINT, pick_word(), 1'($urandom_range(0, 1)));
  endtask

  // Halt the machine by one cause chosen at random.
  task automatic test_halt_cause();
    halt_cause_t cause;
    cause = halt_cause_t'($urandom_range(0, int'(CAUSE_OVERFLOW)));
    case (cause)
      CAUSE_EOF: begin
        issue_instr(OP_READ, pick_word(), 1'b0);
      end
      CAUSE_STOP: begin
        issue_instr(OP_STOP, pick_word(), 1'($urandom_range(0, 1)));
      end
      CAUSE_UNKNOWN_OP: begin
        issue_instr(3'($urandom_range(OpUnusedLo, OpUnusedHi)), pick_word(),
                    1'($urandom_range(0, 1)));
      end
      CAUSE_ADD_UNDER: begin
        while (stack_fill >= 2) issue_instr(OP_PRINT, pick_word(), 1'b0);
        issue_instr(OP_ADD, pick_word(), 1'($urandom_range(0, 1)));
      end
      CAUSE_PRINT_EMPTY: begin
        while (stack_fill > 0) issue_instr(OP_PRINT, pick_word(), 1'b1);
        issue_instr(OP_PRINT, pick_word(), 1'($urandom_range(0, 1)));
      end
      default: begin
        // Overflow: top up to full, then push or read one more.
        while (stack_fill < StackDepth) issue_instr(OP_PUSH, pick_word(), 1'b1);
        issue_instr($urandom_range(0, 1) ? OP_READ : OP_PUSH, pick_word(), 1'b1);
      end
    endcase
  endtask

  // Once halted, every op, the unused codes included, reports halted.
  task automatic test_halted_tail();
    repeat (12) issue_instr(3'($urandom_range(0, 7)), pick_word(), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    // Hold reset, then release it on a falling edge.
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    test_wrapping_add();
    test_read_supplied();
    test_ignored_fields();
    test_stack_order();
    test_random_program();
    test_fill_to_capacity();
    test_halt_cause();
    test_halted_tail();

    // Let the last results come back, then wait so that any stray beat can show up.
    wait_drained();
    repeat (SettleCycles) @(negedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
